### sv/flp_pkg.sv
// ----------------------------------------------------------------------------
// flp_pkg
// Types, codes and defaults shared by the foil energy-loss interpolator.
// ----------------------------------------------------------------------------
package flp_pkg;

  localparam int unsigned MaxParticlesDef = 20;
  localparam int unsigned MaxPointsDef    = 256;
  localparam int unsigned FractionBitsDef = 12;

  localparam int unsigned EW  = 24;  // energy width
  localparam int unsigned SGW = 16;  // straggle width
  localparam int unsigned MW  = 12;  // mass width

  localparam logic [11:0] MassTol       = 12'd8;
  localparam logic signed [23:0] StoppedEnergy = -24'sd16;
  localparam logic signed [25:0] EnergyMaxPos  = 26'sd8388607;
  localparam logic signed [25:0] EnergyMinNeg  = -26'sd8388608;

  typedef enum logic [1:0] {
    KIND_LOAD_SLOT  = 2'd0,
    KIND_LOAD_POINT = 2'd1,
    KIND_QUERY      = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OUT_PASSED    = 2'd0,
    OUT_BELOW_MIN = 2'd1,
    OUT_UNKNOWN   = 2'd2,
    OUT_DISABLED  = 2'd3
  } outcome_e;

  typedef enum logic [2:0] {
    CFG_ENABLED        = 3'd0,
    CFG_MIN_ENERGY     = 3'd1,
    CFG_ENERGY_STEP    = 3'd2,
    CFG_POINT_COUNT    = 3'd3,
    CFG_PARTICLE_COUNT = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic [4:0]         slot;
    logic [7:0]         point;
    logic [6:0]         atomic_number;
    logic [11:0]        particle_mass;
    logic [23:0]        incident_energy;
    logic signed [23:0] table_energy;
    logic [15:0]        table_straggle;
  } in_beat_t;

  typedef struct packed {
    logic signed [23:0] exit_energy;
    logic [15:0]        exit_straggle;
    logic [1:0]         outcome;
  } out_beat_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [23:0] value;
  } cfg_beat_t;

  typedef struct packed {
    logic        enabled;
    logic [23:0] min_energy;
    logic [23:0] energy_step;
    logic [8:0]  point_count;
    logic [4:0]  particle_count;
  } cfg_t;

  // Per-item control that travels down the pipeline.
  typedef struct packed {
    logic [1:0]         kind;
    logic [4:0]         slot;     // load slot, or matched slot for a query
    logic [7:0]         point;
    logic signed [23:0] tab_e;
    logic [15:0]        tab_s;
    logic [1:0]         outcome;
    logic signed [23:0] energy;   // result energy when not interpolated
    logic               at_top;
    logic [23:0]        over;     // distance past the last grid point
    logic [8:0]         last;     // index of the last grid point
  } ctl_t;

endpackage

### sv/flp_chan_if.sv
// ----------------------------------------------------------------------------
// flp_chan_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface flp_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/foil_energy_loss_interpolator_top.sv
// ----------------------------------------------------------------------------
// foil_energy_loss_interpolator_top
// Matches a particle and interpolates exit energy and straggle on a grid.
//
//   channel  dir  payload       notes
//   cfg_i    in   cfg_beat_t    register writes, always ready
//   in_i     in   in_beat_t     slot loads, grid loads, queries
//   out_o    out  out_beat_t    one beat per query
//
// One beat enters per cycle unless out_o stalls; a beat passes the input register,
// the front, the one-bit-per-stage divider, the table and the output register.
// Reset clears valid bits and sets the config defaults; tables hold garbage until loaded.
// A stall on out_o freezes the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module foil_energy_loss_interpolator_top import flp_pkg::*; #(
  parameter int unsigned MAX_PARTICLES = MaxParticlesDef,
  parameter int unsigned MAX_POINTS    = MaxPointsDef,
  parameter int unsigned FRACTION_BITS = FractionBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  flp_chan_if.sink   cfg_i,
  flp_chan_if.sink   in_i,
  flp_chan_if.source out_o
);

  localparam int unsigned IW = $clog2(MAX_POINTS);
  localparam int unsigned QW = IW + FRACTION_BITS;
  localparam int unsigned RW = 24 + FRACTION_BITS;

  cfg_t      cfg_d, cfg_q;
  logic      en;
  logic      in_v_q;
  in_beat_t  in_q;
  logic      out_v_q;
  out_beat_t out_q;

  logic        fr_v;
  ctl_t        fr_ctl;
  logic [23:0] fr_d;
  logic [23:0] fr_step;

  logic          dv   [QW+1];
  ctl_t          dctl [QW+1];
  logic [RW-1:0] drem [QW+1];
  logic [QW-1:0] dquo [QW+1];
  logic [23:0]   dstp [QW+1];

  logic        tb_v;
  logic [1:0]  tb_kind;
  out_beat_t   tb_beat;

  assign en          = !out_v_q || out_o.ready;
  assign in_i.ready  = en;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.data.index)
        CFG_ENABLED:        cfg_d.enabled        = cfg_i.data.value[0];
        CFG_MIN_ENERGY:     cfg_d.min_energy     = cfg_i.data.value;
        CFG_ENERGY_STEP:    cfg_d.energy_step    = cfg_i.data.value;
        CFG_POINT_COUNT:    cfg_d.point_count    = cfg_i.data.value[8:0];
        CFG_PARTICLE_COUNT: cfg_d.particle_count = cfg_i.data.value[4:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enabled        <= 1'b0;
      cfg_q.min_energy     <= '0;
      cfg_q.energy_step    <= 24'd16;
      cfg_q.point_count    <= 9'd2;
      cfg_q.particle_count <= 5'd1;
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
      if (en) begin
        in_v_q  <= in_i.valid;
        out_v_q <= tb_v && tb_kind == KIND_QUERY;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q  <= in_i.data;
      out_q <= tb_beat;
    end
  end

  flp_front #(
    .MAX_PARTICLES(MAX_PARTICLES),
    .MAX_POINTS   (MAX_POINTS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_v_q),
    .beat_i  (in_q),
    .cfg_i   (cfg_q),
    .valid_o (fr_v),
    .ctl_o   (fr_ctl),
    .d_o     (fr_d),
    .step_o  (fr_step)
  );

  assign dv[0]   = fr_v;
  assign dctl[0] = fr_ctl;
  assign drem[0] = {fr_d, {FRACTION_BITS{1'b0}}};
  assign dquo[0] = '0;
  assign dstp[0] = fr_step;

  for (genvar g = 0; g < QW; g++) begin : g_div
    flp_div_step #(
      .QW (QW),
      .FB (FRACTION_BITS),
      .BIT(QW - 1 - g)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv[g]),
      .ctl_i   (dctl[g]),
      .rem_i   (drem[g]),
      .quo_i   (dquo[g]),
      .step_i  (dstp[g]),
      .valid_o (dv[g+1]),
      .ctl_o   (dctl[g+1]),
      .rem_o   (drem[g+1]),
      .quo_o   (dquo[g+1]),
      .step_o  (dstp[g+1])
    );
  end

  flp_table #(
    .MAX_PARTICLES(MAX_PARTICLES),
    .MAX_POINTS   (MAX_POINTS),
    .FB           (FRACTION_BITS)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv[QW]),
    .ctl_i   (dctl[QW]),
    .quo_i   (dquo[QW]),
    .valid_o (tb_v),
    .kind_o  (tb_kind),
    .beat_o  (tb_beat)
  );

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.outcome != OUT_PASSED |-> out_q.exit_straggle == '0)
    else $error("straggle nonzero on a non-passed result");

  a_stop_energy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && (out_q.outcome == OUT_BELOW_MIN || out_q.outcome == OUT_UNKNOWN)
    |-> out_q.exit_energy == StoppedEnergy)
    else $error("stopped result without stopped energy");

  a_disabled_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.outcome == OUT_DISABLED |-> !out_q.exit_energy[23])
    else $error("pass-through energy went negative");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(in_v_q) && $stable(dv[QW]))
    else $error("pipeline moved during a stall");

endmodule

### sv/flp_front.sv
// ----------------------------------------------------------------------------
// flp_front
// Particle list, classification, grid offset and top-of-grid check.
// ----------------------------------------------------------------------------
module flp_front import flp_pkg::*; #(
  parameter int unsigned MAX_PARTICLES = MaxParticlesDef,
  parameter int unsigned MAX_POINTS    = MaxPointsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  in_beat_t    beat_i,
  input  cfg_t        cfg_i,
  output logic        valid_o,
  output ctl_t        ctl_o,
  output logic [23:0] d_o,
  output logic [23:0] step_o
);

  localparam int unsigned SW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

  logic [6:0]  z_q    [MAX_PARTICLES];
  logic [11:0] mass_q [MAX_PARTICLES];

  logic        found;
  logic [4:0]  match_idx;
  logic [5:0]  pc;
  logic [12:0] mdiff;
  logic [8:0]  n;
  logic [8:0]  last;
  ctl_t        ctl_d;
  logic [23:0] d_d;
  logic [23:0] step_d;
  logic [32:0] top_d;

  logic        v2_q;
  ctl_t        ctl2_q;
  logic [23:0] d2_q;
  logic [23:0] step2_q;
  logic [32:0] top2_q;

  logic        v3_q;
  ctl_t        ctl3_d;
  ctl_t        ctl3_q;
  logic [23:0] d3_q;
  logic [23:0] step3_q;

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i && beat_i.kind == KIND_LOAD_SLOT &&
        32'(beat_i.slot) < MAX_PARTICLES) begin
      z_q[beat_i.slot[SW-1:0]]    <= beat_i.atomic_number;
      mass_q[beat_i.slot[SW-1:0]] <= beat_i.particle_mass;
    end
  end

  always_comb begin
    pc = (32'(cfg_i.particle_count) > MAX_PARTICLES) ? 6'(MAX_PARTICLES)
                                                      : {1'b0, cfg_i.particle_count};
    found     = 1'b0;
    match_idx = '0;
    mdiff     = '0;
    for (int s = 0; s < MAX_PARTICLES; s++) begin
      mdiff = {1'b0, mass_q[s]} - {1'b0, beat_i.particle_mass};
      if (!found && 6'(s) < pc && z_q[s] == beat_i.atomic_number &&
          ($signed(mdiff) < $signed({1'b0, MassTol})) &&
          ($signed(mdiff) > -$signed({1'b0, MassTol}))) begin
        found     = 1'b1;
        match_idx = 5'(s);
      end
    end

    if (cfg_i.point_count < 9'd2) begin
      n = 9'd2;
    end else if (32'(cfg_i.point_count) > MAX_POINTS) begin
      n = 9'(MAX_POINTS);
    end else begin
      n = cfg_i.point_count;
    end
    last   = n - 9'd1;
    step_d = (cfg_i.energy_step == '0) ? 24'd1 : cfg_i.energy_step;
    d_d    = beat_i.incident_energy - cfg_i.min_energy;
    top_d  = 33'(last) * 33'(step_d);

    ctl_d        = '0;
    ctl_d.kind   = beat_i.kind;
    ctl_d.slot   = beat_i.slot;
    ctl_d.point  = beat_i.point;
    ctl_d.tab_e  = beat_i.table_energy;
    ctl_d.tab_s  = beat_i.table_straggle;
    ctl_d.last   = last;
    if (!cfg_i.enabled) begin
      ctl_d.outcome = OUT_DISABLED;
      ctl_d.energy  = beat_i.incident_energy[23] ? 24'sh7fffff
                                                 : $signed(beat_i.incident_energy);
    end else if (beat_i.incident_energy < cfg_i.min_energy) begin
      ctl_d.outcome = OUT_BELOW_MIN;
      ctl_d.energy  = StoppedEnergy;
    end else if (!found) begin
      ctl_d.outcome = OUT_UNKNOWN;
      ctl_d.energy  = StoppedEnergy;
    end else begin
      ctl_d.outcome = OUT_PASSED;
      ctl_d.energy  = StoppedEnergy;
    end
    if (beat_i.kind == KIND_QUERY) begin
      ctl_d.slot = match_idx;
    end
  end

  always_comb begin
    ctl3_d        = ctl2_q;
    ctl3_d.at_top = {9'd0, d2_q} >= top2_q;
    ctl3_d.over   = d2_q - top2_q[23:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= valid_i;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl2_q  <= ctl_d;
      d2_q    <= d_d;
      step2_q <= step_d;
      top2_q  <= top_d;
      ctl3_q  <= ctl3_d;
      d3_q    <= d2_q;
      step3_q <= step2_q;
    end
  end

  assign valid_o = v3_q;
  assign ctl_o   = ctl3_q;
  assign d_o     = d3_q;
  assign step_o  = step3_q;

endmodule

### sv/flp_div_step.sv
// ----------------------------------------------------------------------------
// flp_div_step
// One restoring division step: resolve one quotient bit of offset / step.
// ----------------------------------------------------------------------------
module flp_div_step import flp_pkg::*; #(
  parameter int unsigned QW  = 20,
  parameter int unsigned FB  = FractionBitsDef,
  parameter int unsigned BIT = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  ctl_t               ctl_i,
  input  logic [24+FB-1:0]   rem_i,
  input  logic [QW-1:0]      quo_i,
  input  logic [23:0]        step_i,
  output logic               valid_o,
  output ctl_t               ctl_o,
  output logic [24+FB-1:0]   rem_o,
  output logic [QW-1:0]      quo_o,
  output logic [23:0]        step_o
);

  localparam int unsigned RW = 24 + FB;
  localparam int unsigned DW = 24 + QW;

  logic [DW-1:0] sh;
  logic          ge;
  logic [RW-1:0] rem_d;
  logic [QW-1:0] quo_d;
  logic          valid_q;

  always_comb begin
    sh    = DW'(step_i) << BIT;
    ge    = DW'(rem_i) >= sh;
    rem_d = ge ? RW'(DW'(rem_i) - sh) : rem_i;
    quo_d = quo_i;
    quo_d[BIT] = ge;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_o  <= ctl_i;
      rem_o  <= rem_d;
      quo_o  <= quo_d;
      step_o <= step_i;
    end
  end

  assign valid_o = valid_q;

endmodule

### sv/flp_table.sv
// ----------------------------------------------------------------------------
// flp_table
// Grid tables, neighbor read and linear interpolation.
// ----------------------------------------------------------------------------
module flp_table import flp_pkg::*; #(
  parameter int unsigned MAX_PARTICLES = MaxParticlesDef,
  parameter int unsigned MAX_POINTS    = MaxPointsDef,
  parameter int unsigned FB            = FractionBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  ctl_t                      ctl_i,
  input  logic [$clog2(MAX_POINTS)+FB-1:0] quo_i,
  output logic                      valid_o,
  output logic [1:0]                kind_o,
  output out_beat_t                 beat_o
);

  localparam int unsigned IW    = $clog2(MAX_POINTS);
  localparam int unsigned SW    = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int unsigned DEPTH = MAX_PARTICLES * (2 ** IW);
  localparam int unsigned PEW   = 26 + FB;
  localparam int unsigned PSW   = 18 + FB;

  logic signed [23:0] mem_e [DEPTH];
  logic [15:0]        mem_s [DEPTH];

  logic [IW-1:0]      idx;
  logic [FB-1:0]      frac;
  logic [IW-1:0]      addr_a;
  logic [IW-1:0]      addr_b;
  logic               wr_en;

  logic               v1_q;
  ctl_t               ctl1_q;
  logic [FB-1:0]      f1_q;
  logic signed [23:0] ea_q, eb_q;
  logic [15:0]        sa_q, sb_q;

  logic signed [24:0]    de;
  logic signed [16:0]    ds;
  logic signed [PEW-1:0] pe_d;
  logic signed [PSW-1:0] ps_d;

  logic                  v2_q;
  ctl_t                  ctl2_q;
  logic signed [23:0]    ea2_q;
  logic [15:0]           sa2_q;
  logic signed [PEW-1:0] pe_q;
  logic signed [PSW-1:0] ps_q;

  logic signed [PEW-1:0] pe_sh;
  logic signed [PSW-1:0] ps_sh;
  logic signed [25:0]    sum;
  logic signed [23:0]    sat;
  logic [15:0]           strag;

  always_comb begin
    idx    = quo_i[IW+FB-1:FB];
    frac   = quo_i[FB-1:0];
    addr_a = ctl_i.at_top ? IW'(ctl_i.last) : idx;
    addr_b = idx + IW'(1);
    wr_en  = valid_i && ctl_i.kind == KIND_LOAD_POINT &&
             32'(ctl_i.slot) < MAX_PARTICLES && 32'(ctl_i.point) < MAX_POINTS;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (wr_en) begin
        mem_e[{ctl_i.slot[SW-1:0], IW'(ctl_i.point)}] <= ctl_i.tab_e;
        mem_s[{ctl_i.slot[SW-1:0], IW'(ctl_i.point)}] <= ctl_i.tab_s;
      end
      ea_q <= mem_e[{ctl_i.slot[SW-1:0], addr_a}];
      eb_q <= mem_e[{ctl_i.slot[SW-1:0], addr_b}];
      sa_q <= mem_s[{ctl_i.slot[SW-1:0], addr_a}];
      sb_q <= mem_s[{ctl_i.slot[SW-1:0], addr_b}];
      ctl1_q <= ctl_i;
      f1_q   <= frac;
    end
  end

  always_comb begin
    de   = 25'(eb_q) - 25'(ea_q);
    ds   = $signed({1'b0, sb_q}) - $signed({1'b0, sa_q});
    pe_d = PEW'(de) * $signed(PEW'({1'b0, f1_q}));
    ps_d = PSW'(ds) * $signed(PSW'({1'b0, f1_q}));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl2_q <= ctl1_q;
      ea2_q  <= ea_q;
      sa2_q  <= sa_q;
      pe_q   <= pe_d;
      ps_q   <= ps_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_comb begin
    pe_sh = pe_q >>> FB;
    ps_sh = ps_q >>> FB;
    if (ctl2_q.at_top) begin
      sum   = $signed({2'b00, ctl2_q.over}) + 26'(ea2_q);
      strag = sa2_q;
    end else begin
      sum   = 26'(ea2_q) + pe_sh[25:0];
      strag = sa2_q + ps_sh[15:0];
    end
    if (sum > EnergyMaxPos) begin
      sat = EnergyMaxPos[23:0];
    end else if (sum < EnergyMinNeg) begin
      sat = EnergyMinNeg[23:0];
    end else begin
      sat = sum[23:0];
    end
    beat_o.outcome = ctl2_q.outcome;
    if (ctl2_q.outcome == OUT_PASSED) begin
      beat_o.exit_energy   = sat;
      beat_o.exit_straggle = strag;
    end else begin
      beat_o.exit_energy   = ctl2_q.energy;
      beat_o.exit_straggle = '0;
    end
  end

  assign valid_o = v2_q;
  assign kind_o  = ctl2_q.kind;

endmodule
